FILE: rtl/core/rgb_to_hsl_channel_extract_macros.svh
// ----------------------------------------------------------------------------
// rgb_to_hsl_channel_extract_macros
// assertion helpers shared by the rgb to hsl channel extractor
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CHANNEL_EXTRACT_MACROS_SVH
`define RGB_TO_HSL_CHANNEL_EXTRACT_MACROS_SVH

// same-cycle implication, checked out of reset
`define RTHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RTHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/rths_pkg.sv
// ----------------------------------------------------------------------------
// rths_pkg
// types and constants of the rgb to hsl channel extractor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rths_pkg;

  localparam int PIX_W     = 8;
  localparam int SEL_W     = 3;
  localparam int NUM_W     = 19;
  localparam int DEN_W     = 11;
  localparam int Q_W       = 8;
  localparam int DIV_STEPS = 2;
  localparam int APB_W     = 32;
  localparam int ADDR_W    = 3;

  typedef enum logic [SEL_W-1:0] {
    CH_RED   = 3'd0,
    CH_GREEN = 3'd1,
    CH_BLUE  = 3'd2,
    CH_HUE   = 3'd3,
    CH_SAT   = 3'd4,
    CH_LUM   = 3'd5
  } chsel_t;

  typedef enum logic [1:0] {
    MX_RED   = 2'd0,
    MX_GREEN = 2'd1,
    MX_BLUE  = 2'd2
  } maxc_t;

  typedef struct packed {
    logic             use_div;
    logic [PIX_W-1:0] direct;
  } side_t;

endpackage

FILE: rtl/core/rths_div.sv
// ----------------------------------------------------------------------------
// rths_div
// pipelined restoring divider, two quotient bits per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rths_div import rths_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  side_t            in_side,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_q,
  output side_t            out_side
);

  localparam int STAGES = Q_W / DIV_STEPS;

  logic [STAGES-1:0] vld_r;
  logic [NUM_W-1:0]  rem_r  [STAGES];
  logic [DEN_W-1:0]  den_r  [STAGES];
  logic [Q_W-1:0]    q_r    [STAGES];
  side_t             side_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic             vld_src;
    logic [NUM_W-1:0] rem_src;
    logic [DEN_W-1:0] den_src;
    logic [Q_W-1:0]   q_src;
    side_t            side_src;
    logic [NUM_W-1:0] rem_nxt;
    logic [Q_W-1:0]   q_nxt;

    if (k == 0) begin : g_first
      assign vld_src  = in_valid;
      assign rem_src  = in_num;
      assign den_src  = in_den;
      assign q_src    = '0;
      assign side_src = in_side;
    end else begin : g_next
      assign vld_src  = vld_r[k-1];
      assign rem_src  = rem_r[k-1];
      assign den_src  = den_r[k-1];
      assign q_src    = q_r[k-1];
      assign side_src = side_r[k-1];
    end

    always_comb begin
      logic [NUM_W-1:0] trial;
      rem_nxt = rem_src;
      q_nxt   = q_src;
      for (int j = 0; j < DIV_STEPS; j++) begin
        trial = NUM_W'(den_src) << (Q_W - 1 - k * DIV_STEPS - j);
        if (rem_nxt >= trial) begin
          rem_nxt = rem_nxt - trial;
          q_nxt   = {q_nxt[Q_W-2:0], 1'b1};
        end else begin
          q_nxt   = {q_nxt[Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_src;
        q_r[k]    <= q_nxt;
        side_r[k] <= side_src;
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_q     = q_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

endmodule

FILE: rtl/core/rgb_to_hsl_channel_extract.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_channel_extract
// picks red, green, blue, hue, saturation or luminosity of an rgb pixel
//
//   port group   dir  handshake          carries
//   in_*         in   in_valid/in_ready  red, green, blue (8b each)
//   out_*        out  out_valid/out_ready channel_value (8b)
//   apb          in   psel/penable       channel_select at address 0
//
// one word per clock sustained unless out_ready holds off the output
// stages are capture, max/min, numerator build, 4 divider stages, output
// synchronous active-low reset clears valid bits and channel_select
// a stalled output freezes the whole pipeline, in_ready follows it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgb_to_hsl_channel_extract_macros.svh"

module rgb_to_hsl_channel_extract import rths_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  in_red,
  input  logic [PIX_W-1:0]  in_green,
  input  logic [PIX_W-1:0]  in_blue,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  out_channel_value,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready
);

  logic en;

  // configuration
  logic [SEL_W-1:0] sel_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= CH_RED;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      sel_r <= pwdata[SEL_W-1:0];
    end
  end

  assign prdata = paddr[2] ? '0 : APB_W'(sel_r);

  // stage 1: capture
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_r_r, s1_g_r, s1_b_r;

  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r_r <= in_red;
      s1_g_r <= in_green;
      s1_b_r <= in_blue;
    end
  end

  // stage 2: max, min, range, sum, direct value
  logic             s2_valid_r;
  logic [PIX_W-1:0] s2_r_r, s2_g_r, s2_b_r, s2_dl_r;
  logic [PIX_W:0]   s2_sum_r;
  maxc_t            s2_maxc_r;
  logic             s2_hue_r;
  side_t            s2_side_r;

  logic [PIX_W-1:0] mx_nxt, mn_nxt, dl_nxt;
  logic [PIX_W:0]   sum_nxt;
  maxc_t            maxc_nxt;
  side_t            side_nxt;

  always_comb begin
    mx_nxt = (s1_r_r > s1_g_r) ? s1_r_r : s1_g_r;
    mx_nxt = (mx_nxt > s1_b_r) ? mx_nxt : s1_b_r;
    mn_nxt = (s1_r_r < s1_g_r) ? s1_r_r : s1_g_r;
    mn_nxt = (mn_nxt < s1_b_r) ? mn_nxt : s1_b_r;
    dl_nxt  = mx_nxt - mn_nxt;
    sum_nxt = {1'b0, mx_nxt} + {1'b0, mn_nxt};
    if (mx_nxt == s1_r_r) begin
      maxc_nxt = MX_RED;
    end else if (mx_nxt == s1_g_r) begin
      maxc_nxt = MX_GREEN;
    end else begin
      maxc_nxt = MX_BLUE;
    end
    side_nxt.use_div = 1'b0;
    side_nxt.direct  = '0;
    case (sel_r)
      CH_RED:   side_nxt.direct = s1_r_r;
      CH_GREEN: side_nxt.direct = s1_g_r;
      CH_BLUE:  side_nxt.direct = s1_b_r;
      CH_HUE, CH_SAT: side_nxt.use_div = (dl_nxt != '0);
      CH_LUM:   side_nxt.direct = sum_nxt[PIX_W:1];
      default:  side_nxt.direct = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r_r    <= s1_r_r;
      s2_g_r    <= s1_g_r;
      s2_b_r    <= s1_b_r;
      s2_dl_r   <= dl_nxt;
      s2_sum_r  <= sum_nxt;
      s2_maxc_r <= maxc_nxt;
      s2_hue_r  <= (sel_r == CH_HUE);
      s2_side_r <= side_nxt;
    end
  end

  // stage 3: dividend and divisor
  logic             s3_valid_r;
  logic [NUM_W-1:0] s3_num_r;
  logic [DEN_W-1:0] s3_den_r;
  side_t            s3_side_r;

  logic signed [DEN_W:0] m_raw;
  logic [DEN_W-1:0]      m_u, dl6;
  logic [PIX_W:0]        sden;
  logic [NUM_W-1:0]      num_nxt;
  logic [DEN_W-1:0]      den_nxt;

  always_comb begin
    dl6 = DEN_W'({s2_dl_r, 2'b00}) + DEN_W'({s2_dl_r, 1'b0});
    case (s2_maxc_r)
      MX_RED:   m_raw = $signed({4'b0, s2_g_r}) - $signed({4'b0, s2_b_r});
      MX_GREEN: m_raw = $signed({4'b0, s2_b_r}) - $signed({4'b0, s2_r_r})
                        + $signed({3'b0, s2_dl_r, 1'b0});
      MX_BLUE:  m_raw = $signed({4'b0, s2_r_r}) - $signed({4'b0, s2_g_r})
                        + $signed({2'b0, s2_dl_r, 2'b00});
      default:  m_raw = '0;
    endcase
    if (m_raw < 0) begin
      m_raw = m_raw + $signed({1'b0, dl6});
    end
    m_u  = m_raw[DEN_W-1:0];
    sden = (s2_sum_r <= (PIX_W+1)'(255)) ? s2_sum_r
                                          : (PIX_W+1)'(10'd510 - {1'b0, s2_sum_r});
    if (s2_hue_r) begin
      num_nxt = {m_u, 8'b0} - {8'b0, m_u};
      den_nxt = dl6;
    end else begin
      num_nxt = {3'b0, s2_dl_r, 8'b0} - {11'b0, s2_dl_r};
      den_nxt = {2'b0, sden};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_num_r  <= num_nxt;
      s3_den_r  <= den_nxt;
      s3_side_r <= s2_side_r;
    end
  end

  // stages 4 to 7: divider
  logic           dv_valid;
  logic [Q_W-1:0] dv_q;
  side_t          dv_side;

  rths_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_valid_r),
    .in_num    (s3_num_r),
    .in_den    (s3_den_r),
    .in_side   (s3_side_r),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  // stage 8: output word
  logic             out_valid_r;
  logic [PIX_W-1:0] out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= dv_side.use_div ? dv_q : dv_side.direct;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_value = out_value_r;

  // checks
  `RTHS_ASSERT_NOW(a_hue_range, out_valid_r && sel_r == CH_HUE, out_value_r != 8'hFF, "hue too high")
  `RTHS_ASSERT_NOW(a_unused_zero, out_valid_r && sel_r > CH_LUM, out_value_r == '0, "nonzero word")
  `RTHS_ASSERT_NEXT(a_div_den, en && s2_valid_r && s2_side_r.use_div, s3_den_r != '0, "zero divisor")

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the rgb to hsl channel extractor
//
// pixels go in on a valid/ready channel. Each accepted word is run through an
// integer model of the red, green, blue, hue, saturation and luminosity
// selections. The model uses the channel_select value last written over apb.
// Output words are checked in order against the predicted values. Both sides
// idle at random, and once the output holds off long enough to back up the
// pipeline. channel_select is rewritten between phases while the block is
// empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rths_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  localparam logic [ADDR_W-1:0] SELECT_ADDR = 3'd0;
  localparam logic [ADDR_W-1:0] SPARE_ADDR  = 3'd4;
  localparam logic [SEL_W-1:0]  SEL_SPARE_LO = 3'd6;
  localparam logic [SEL_W-1:0]  SEL_SPARE_HI = 3'd7;
  localparam int PRESS_AT  = 400;
  localparam int STALL_LEN = 150;
  localparam int DRAIN_CYC = 20;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  in_red = '0;
  logic [PIX_W-1:0]  in_green = '0;
  logic [PIX_W-1:0]  in_blue = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PIX_W-1:0]  out_channel_value;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [APB_W-1:0]  pwdata = '0;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  pixel_t           pixel_q[$];
  logic [PIX_W-1:0] channel_q[$];
  logic [SEL_W-1:0] cur_select = CH_RED;
  pixel_t           drv_px;
  bit               idle_en = 1'b1;
  int               n_sent = 0;
  int               n_accepted = 0;
  int               n_results = 0;
  int               n_errors = 0;
  int               stall_left = 0;
  bit               stall_done = 1'b0;

  rgb_to_hsl_channel_extract uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_value (out_channel_value),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [PIX_W-1:0] expected_channel(input pixel_t px,
                                                         input logic [SEL_W-1:0] sel);
    int ri, gi, bi, mx, mn, dl, n, sum, den;
    logic [PIX_W-1:0] v;
    ri = px.red;
    gi = px.green;
    bi = px.blue;
    mx = (ri > gi) ? ri : gi;
    mx = (mx > bi) ? mx : bi;
    mn = (ri < gi) ? ri : gi;
    mn = (mn < bi) ? mn : bi;
    dl = mx - mn;
    sum = mx + mn;
    case (sel)
      CH_RED:   v = px.red;
      CH_GREEN: v = px.green;
      CH_BLUE:  v = px.blue;
      CH_HUE: begin
        if (dl == 0) begin
          v = '0;
        end else begin
          if (mx == ri) n = 60 * (gi - bi);
          else if (mx == gi) n = 60 * (bi - ri) + 120 * dl;
          else n = 60 * (ri - gi) + 240 * dl;
          if (n < 0) n += 360 * dl;
          v = PIX_W'((n * 255) / (360 * dl));
        end
      end
      CH_SAT: begin
        den = (sum <= 255) ? sum : 510 - sum;
        if (dl == 0 || den == 0) v = '0;
        else v = PIX_W'((dl * 255) / den);
      end
      CH_LUM:   v = PIX_W'(sum / 2);
      default:  v = '0;
    endcase
    return v;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    int kind;
    logic [PIX_W-1:0] hi, lo;
    px.red   = PIX_W'($urandom);
    px.green = PIX_W'($urandom);
    px.blue  = PIX_W'($urandom);
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        px.green = px.red;
        px.blue  = px.red;
      end
      1: begin
        hi = PIX_W'($urandom_range(1, 255));
        lo = PIX_W'($urandom_range(0, hi - 1));
        case ($urandom_range(0, 2))
          0:       px = {hi, hi, lo};
          1:       px = {lo, hi, hi};
          default: px = {hi, lo, hi};
        endcase
      end
      2: begin
        if ($urandom_range(0, 2) != 0) px.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        if ($urandom_range(0, 2) != 0) px.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        if ($urandom_range(0, 2) != 0) px.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      default: ;
    endcase
    return px;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_q.size() != 0 && !(idle_en && $urandom_range(0, 99) < 31)) begin
        drv_px = pixel_q.pop_front();
        in_valid <= 1'b1;
        in_red   <= drv_px.red;
        in_green <= drv_px.green;
        in_blue  <= drv_px.blue;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks output words, predicts accepted input words
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (channel_q.size() == 0) begin
          if (n_errors < 10)
            $display("unexpected word: channel_value %0d", out_channel_value);
          n_errors++;
        end else if (out_channel_value !== channel_q[0]) begin
          if (n_errors < 10)
            $display("mismatch: channel_value expected %0d got %0d (select %0d)",
                     channel_q[0], out_channel_value, cur_select);
          n_errors++;
          void'(channel_q.pop_front());
        end else begin
          void'(channel_q.pop_front());
        end
        n_results <= n_results + 1;
      end
      if (in_valid && in_ready) begin
        channel_q.insert(channel_q.size(),
                         expected_channel({in_red, in_green, in_blue}, cur_select));
        n_accepted <= n_accepted + 1;
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!stall_done && in_valid && n_accepted >= PRESS_AT) begin
        stall_done <= 1'b1;
        stall_left <= STALL_LEN;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_en && $urandom_range(0, 99) < 31);
      end
    end
  end

  task automatic push_pixel(input logic [PIX_W-1:0] r, g, b);
    pixel_q.insert(pixel_q.size(), {r, g, b});
    n_sent++;
  endtask

  task automatic push_random(input int count);
    repeat (count) begin
      pixel_q.insert(pixel_q.size(), rand_pixel());
      n_sent++;
    end
  endtask

  task automatic wait_idle();
    while (n_results != n_sent) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [APB_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == SELECT_ADDR) cur_select = data[SEL_W-1:0];
  endtask

  task automatic push_corners();
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd0, 8'd255);
    push_pixel(8'd255, 8'd255, 8'd0);
    push_pixel(8'd0, 8'd255, 8'd255);
    push_pixel(8'd0, 8'd0, 8'd255);
    push_pixel(8'd255, 8'd254, 8'd255);
    push_pixel(8'd200, 8'd100, 8'd50);
  endtask

  initial begin
    logic [SEL_W-1:0] sel_plan[10];
    int count;
    sel_plan = '{CH_LUM, SEL_SPARE_HI, CH_RED, CH_HUE, CH_GREEN,
                 CH_BLUE, CH_SAT, SEL_SPARE_LO, CH_HUE, CH_SAT};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of the selector is red
    push_pixel(8'd0, 8'd255, 8'd17);
    push_pixel(8'd255, 8'd0, 8'd170);
    wait_idle();

    write_reg(SELECT_ADDR, {29'($urandom), 3'(CH_HUE)});
    push_corners();
    wait_idle();
    write_reg(SELECT_ADDR, {29'($urandom), 3'(CH_SAT)});
    push_corners();
    wait_idle();

    // a write to an unmapped register must leave the selector alone
    write_reg(SPARE_ADDR, $urandom);
    push_random(20);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      idle_en = (p != 2);
      write_reg(SELECT_ADDR, {29'($urandom), sel_plan[p]});
      count = (sel_plan[p] == CH_HUE || sel_plan[p] == CH_SAT) ? 150 : 60;
      push_random(count);
      wait_idle();
    end

    if (channel_q.size() != 0) begin
      $display("%0d expected words never arrived", channel_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
